@@ hw/rtl/pfr_pkg.sv @@
package pfr_pkg;

	// Sizing
	localparam int MAX_POINTS     = 128;
	localparam int NUM_OBJECTIVES = 3;
	localparam int OBJ_W          = 32;
	localparam int IN_OBJECTIVES  = 3;
	localparam int IDX_W          = $clog2(MAX_POINTS);
	localparam int CNT_W          = $clog2(MAX_POINTS + 1);
	localparam int DIFF_W         = OBJ_W + 1;
	localparam int POINT_W        = NUM_OBJECTIVES * OBJ_W;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int TAG_W     = 4;
	localparam int PIDX_W    = 7;
	localparam int OUT_CNT_W = 8;
	localparam int TOL_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RANK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_B = 2'd2;

	// Result kinds
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ_ADDR,
		ST_READ_DATA,
		ST_IPICK,
		ST_JSCAN,
		ST_DIFF,
		ST_CMP,
		ST_IWRITE,
		ST_PASS_END
	} pfr_state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic latch_index;
		logic sort_init;
		logic i_next;
		logic j_start;
		logic j_next;
		logic diff_en;
		logic front_write;
		logic pass_end;
		logic out_report;
		logic out_read;
	} pfr_cmd_t;

	typedef struct packed {
		logic i_end;
		logic i_ranked;
		logic j_end;
		logic j_skip;
		logic dominated;
		logic sort_done;
		logic out_busy;
	} pfr_stat_t;

endpackage

@@ hw/rtl/pfr_if.sv @@
interface pfr_in_if;
	import pfr_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [OBJ_W-1:0]  objective_0;
	logic signed [OBJ_W-1:0]  objective_1;
	logic signed [OBJ_W-1:0]  objective_2;
	logic [TAG_W-1:0]         source_tag;
	logic [PIDX_W-1:0]        point_index;

	modport source (output valid, cmd, objective_0, objective_1, objective_2, source_tag,
		point_index, input ready);
	modport sink (input valid, cmd, objective_0, objective_1, objective_2, source_tag,
		point_index, output ready);
endinterface

interface pfr_out_if;
	import pfr_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 result_kind;
	logic [OUT_CNT_W-1:0] front_one_group_a;
	logic [OUT_CNT_W-1:0] front_one_group_b;
	logic [OUT_CNT_W-1:0] point_rank;
	logic [OUT_CNT_W-1:0] points_loaded;
	logic                 load_overflow;

	modport source (output valid, result_kind, front_one_group_a, front_one_group_b,
		point_rank, points_loaded, load_overflow, input ready);
	modport sink (input valid, result_kind, front_one_group_a, front_one_group_b,
		point_rank, points_loaded, load_overflow, output ready);
endinterface

@@ hw/rtl/pfr_ram.sv @@
module pfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hw/rtl/pfr_ctrl.sv @@
module pfr_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [pfr_pkg::CMD_W-1:0] in_cmd,
	output logic                      in_ready,
	input  pfr_pkg::pfr_stat_t        stat,
	output pfr_pkg::pfr_cmd_t         cmd
);
	import pfr_pkg::*;

	pfr_state_t state_q;
	pfr_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !stat.out_busy;
				if (in_valid && !stat.out_busy) begin
					case (in_cmd)
						CMD_LOAD:  cmd.load = 1'b1;
						CMD_CLEAR: cmd.clear = 1'b1;
						CMD_RANK: begin
							cmd.sort_init = 1'b1;
							state_nxt     = ST_IPICK;
						end
						CMD_READ: begin
							cmd.latch_index = 1'b1;
							state_nxt       = ST_READ_ADDR;
						end
						default: ;
					endcase
				end
			end
			ST_READ_ADDR: state_nxt = ST_READ_DATA;
			ST_READ_DATA: begin
				cmd.out_read = 1'b1;
				state_nxt    = ST_IDLE;
			end
			ST_IPICK: begin
				if (stat.i_end) begin
					state_nxt = ST_PASS_END;
				end else if (stat.i_ranked) begin
					cmd.i_next = 1'b1;
				end else begin
					cmd.j_start = 1'b1;
					state_nxt   = ST_JSCAN;
				end
			end
			ST_JSCAN: begin
				if (stat.j_end) begin
					state_nxt = ST_IWRITE;
				end else if (stat.j_skip) begin
					cmd.j_next = 1'b1;
				end else begin
					state_nxt = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff_en = 1'b1;
				state_nxt   = ST_CMP;
			end
			ST_CMP: begin
				// Drop this point from the front on the first dominator found
				if (stat.dominated) begin
					cmd.i_next = 1'b1;
					state_nxt  = ST_IPICK;
				end else begin
					cmd.j_next = 1'b1;
					state_nxt  = ST_JSCAN;
				end
			end
			ST_IWRITE: begin
				cmd.front_write = 1'b1;
				cmd.i_next      = 1'b1;
				state_nxt       = ST_IPICK;
			end
			ST_PASS_END: begin
				cmd.pass_end = 1'b1;
				if (stat.sort_done) begin
					cmd.out_report = 1'b1;
					state_nxt      = ST_IDLE;
				end else begin
					state_nxt = ST_IPICK;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end
endmodule

@@ hw/rtl/pfr_datapath.sv @@
module pfr_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pfr_pkg::pfr_cmd_t                cmd,
	output pfr_pkg::pfr_stat_t               stat,
	input  logic                             cfg_we,
	input  logic [pfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfr_pkg::CFG_W-1:0]        cfg_data,
	input  logic signed [pfr_pkg::OBJ_W-1:0] objective_0,
	input  logic signed [pfr_pkg::OBJ_W-1:0] objective_1,
	input  logic signed [pfr_pkg::OBJ_W-1:0] objective_2,
	input  logic [pfr_pkg::TAG_W-1:0]        source_tag,
	input  logic [pfr_pkg::PIDX_W-1:0]       point_index,
	pfr_out_if.source                        ch_out
);
	import pfr_pkg::*;

	// Configuration
	logic [TOL_W-1:0] tol_q;
	logic [TAG_W-1:0] ga_tag_q;
	logic [TAG_W-1:0] gb_tag_q;

	// Point set bookkeeping
	logic [CNT_W-1:0]      count_q;
	logic                  ovf_q;
	logic [MAX_POINTS-1:0] rank_valid_q;
	logic [MAX_POINTS-1:0] ranked_q;
	logic [MAX_POINTS-1:0] pend_q;

	// Sort counters
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  front_q;
	logic [CNT_W-1:0]  left_q;
	logic [CNT_W-1:0]  found_q;
	logic [CNT_W-1:0]  ga_q;
	logic [CNT_W-1:0]  gb_q;
	logic [PIDX_W-1:0] idx_q;
	logic [DIFF_W-1:0] diff_s1 [NUM_OBJECTIVES];

	// Output register
	logic                 out_valid_q;
	logic                 kind_q;
	logic [OUT_CNT_W-1:0] oa_q;
	logic [OUT_CNT_W-1:0] ob_q;
	logic [OUT_CNT_W-1:0] orank_q;
	logic [OUT_CNT_W-1:0] oloaded_q;
	logic                 oovf_q;

	logic                 full;
	logic                 obj_we;
	logic [POINT_W-1:0]   point_wdata;
	logic [POINT_W-1:0]   pi_rd;
	logic [POINT_W-1:0]   pj_rd;
	logic [TAG_W-1:0]     tag_rd;
	logic [OUT_CNT_W-1:0] rank_rd;
	logic [IDX_W-1:0]     i_idx;
	logic [IDX_W-1:0]     j_idx;
	logic [IDX_W-1:0]     rd_idx;
	logic [IDX_W-1:0]     wr_idx;
	logic [DIFF_W-1:0]    tol_eff;
	logic                 all_le;
	logic                 any_apart;
	logic [CNT_W-1:0]     left_nxt;

	assign full    = (count_q == CNT_W'(MAX_POINTS));
	assign obj_we  = cmd.load && !full;
	assign i_idx   = i_q[IDX_W-1:0];
	assign j_idx   = j_q[IDX_W-1:0];
	assign rd_idx  = IDX_W'(idx_q);
	assign wr_idx  = count_q[IDX_W-1:0];
	assign tol_eff = (tol_q == '0) ? DIFF_W'(1) : DIFF_W'(tol_q);
	assign left_nxt = left_q - found_q;

	// Pack the loaded objectives, extra objectives stored as zero
	always_comb begin
		point_wdata = '0;
		for (int k = 0; k < NUM_OBJECTIVES; k++) begin
			case (k)
				0:       point_wdata[k*OBJ_W +: OBJ_W] = objective_0;
				1:       point_wdata[k*OBJ_W +: OBJ_W] = objective_1;
				2:       point_wdata[k*OBJ_W +: OBJ_W] = objective_2;
				default: point_wdata[k*OBJ_W +: OBJ_W] = '0;
			endcase
		end
	end

	// Objective copies for the candidate and the challenger
	pfr_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_obj_i (
		.clk   (clk),
		.we    (obj_we),
		.waddr (wr_idx),
		.wdata (point_wdata),
		.raddr (i_idx),
		.rdata (pi_rd)
	);

	pfr_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_obj_j (
		.clk   (clk),
		.we    (obj_we),
		.waddr (wr_idx),
		.wdata (point_wdata),
		.raddr (j_idx),
		.rdata (pj_rd)
	);

	pfr_ram #(.WIDTH(TAG_W), .DEPTH(MAX_POINTS)) u_tag (
		.clk   (clk),
		.we    (obj_we),
		.waddr (wr_idx),
		.wdata (source_tag),
		.raddr (i_idx),
		.rdata (tag_rd)
	);

	pfr_ram #(.WIDTH(OUT_CNT_W), .DEPTH(MAX_POINTS)) u_rank (
		.clk   (clk),
		.we    (cmd.front_write),
		.waddr (i_idx),
		.wdata (OUT_CNT_W'(front_q)),
		.raddr (rd_idx),
		.rdata (rank_rd)
	);

	// Dominance of the challenger over the candidate from registered differences
	always_comb begin
		all_le    = 1'b1;
		any_apart = 1'b0;
		for (int k = 0; k < NUM_OBJECTIVES; k++) begin
			if (diff_s1[k][DIFF_W-1]) begin
				all_le = 1'b0;
			end
			if (!diff_s1[k][DIFF_W-1] && (diff_s1[k] >= tol_eff)) begin
				any_apart = 1'b1;
			end
		end
	end

	// Status to the controller
	always_comb begin
		stat.i_end     = (i_q == count_q);
		stat.i_ranked  = ranked_q[i_idx];
		stat.j_end     = (j_q == count_q);
		stat.j_skip    = (j_q == i_q) || ranked_q[j_idx];
		stat.dominated = all_le && any_apart;
		stat.sort_done = (left_nxt == '0);
		stat.out_busy  = out_valid_q && !ch_out.ready;
	end

	// Configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOL_W'(1);
			ga_tag_q <= '0;
			gb_tag_q <= TAG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOL:     tol_q    <= cfg_data[TOL_W-1:0];
				CFG_GROUP_A: ga_tag_q <= cfg_data[TAG_W-1:0];
				CFG_GROUP_B: gb_tag_q <= cfg_data[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	// Point count, overflow and rank valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ovf_q        <= 1'b0;
			rank_valid_q <= '0;
		end else begin
			if (cmd.clear) begin
				count_q      <= '0;
				ovf_q        <= 1'b0;
				rank_valid_q <= '0;
			end else if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q              <= count_q + CNT_W'(1);
					rank_valid_q[wr_idx] <= 1'b0;
				end
			end else if (cmd.front_write) begin
				rank_valid_q[i_idx] <= 1'b1;
			end
		end
	end

	// Sort walk counters and front bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ranked_q <= '0;
			pend_q   <= '0;
			i_q      <= '0;
			j_q      <= '0;
			front_q  <= '0;
			left_q   <= '0;
			found_q  <= '0;
			ga_q     <= '0;
			gb_q     <= '0;
		end else begin
			if (cmd.sort_init) begin
				ranked_q <= '0;
				pend_q   <= '0;
				i_q      <= '0;
				front_q  <= CNT_W'(1);
				left_q   <= count_q;
				found_q  <= '0;
				ga_q     <= '0;
				gb_q     <= '0;
			end
			if (cmd.i_next) begin
				i_q <= i_q + CNT_W'(1);
			end
			if (cmd.j_start) begin
				j_q <= '0;
			end
			if (cmd.j_next) begin
				j_q <= j_q + CNT_W'(1);
			end
			if (cmd.front_write) begin
				pend_q[i_idx] <= 1'b1;
				found_q       <= found_q + CNT_W'(1);
				// First front: tally group tags, group A wins a shared tag
				if (front_q == CNT_W'(1)) begin
					if (tag_rd == ga_tag_q) begin
						ga_q <= ga_q + CNT_W'(1);
					end else if (tag_rd == gb_tag_q) begin
						gb_q <= gb_q + CNT_W'(1);
					end
				end
			end
			if (cmd.pass_end) begin
				ranked_q <= ranked_q | pend_q;
				pend_q   <= '0;
				left_q   <= left_nxt;
				found_q  <= '0;
				front_q  <= front_q + CNT_W'(1);
				i_q      <= '0;
			end
		end
	end

	// Read index and objective differences
	always_ff @(posedge clk) begin
		if (cmd.latch_index) begin
			idx_q <= point_index;
		end
		if (cmd.diff_en) begin
			for (int k = 0; k < NUM_OBJECTIVES; k++) begin
				diff_s1[k] <= {pi_rd[k*OBJ_W + OBJ_W - 1], pi_rd[k*OBJ_W +: OBJ_W]}
					- {pj_rd[k*OBJ_W + OBJ_W - 1], pj_rd[k*OBJ_W +: OBJ_W]};
			end
		end
	end

	// Output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_report || cmd.out_read) begin
			out_valid_q <= 1'b1;
		end else if (ch_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_report) begin
			kind_q    <= KIND_REPORT;
			oa_q      <= OUT_CNT_W'(ga_q);
			ob_q      <= OUT_CNT_W'(gb_q);
			orank_q   <= '0;
			oloaded_q <= OUT_CNT_W'(count_q);
			oovf_q    <= ovf_q;
		end else if (cmd.out_read) begin
			kind_q    <= KIND_READ;
			oa_q      <= '0;
			ob_q      <= '0;
			orank_q   <= ((idx_q < count_q) && rank_valid_q[rd_idx]) ? rank_rd : '0;
			oloaded_q <= OUT_CNT_W'(count_q);
			oovf_q    <= ovf_q;
		end
	end

	assign ch_out.valid             = out_valid_q;
	assign ch_out.result_kind       = kind_q;
	assign ch_out.front_one_group_a = oa_q;
	assign ch_out.front_one_group_b = ob_q;
	assign ch_out.point_rank        = orank_q;
	assign ch_out.points_loaded     = oloaded_q;
	assign ch_out.load_overflow     = oovf_q;

`ifndef ASSERT_OFF
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");

	a_pend_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ranked_q) == '0)
		else $error("point placed in a front twice");

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= count_q)
		else $error("unranked count above point count");

	a_found_bound: assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= left_q)
		else $error("front larger than unranked points");
`endif
endmodule

@@ hw/rtl/pareto_front_ranker_core.sv @@
// Channel   Role     Handshake       Payload
// ch_in     sink     valid / ready   cmd, objective_0..2, source_tag, point_index
// ch_out    source   valid / ready   result_kind, front_one_group_a/b, point_rank,
//                                    points_loaded, load_overflow
// cfg       write    cfg_we          cfg_index, cfg_data
//
// Load and clear complete in idle; a rank read passes the address and data states before
// its result is registered. A rank command walks the set front by front: each unranked
// point is compared pair by pair with registered differences and joins the front if none
// dominates it; the compare through two objective RAM copies sets the pace.
// Reset clears control state, counts and rank valid bits at once; no clearing pass.
// Input is taken only in idle and while the output register is free or being emptied.
module pareto_front_ranker_core (
	input  logic                            clk,
	input  logic                            arst_n,
	pfr_in_if.sink                          ch_in,
	pfr_out_if.source                       ch_out,
	input  logic                            cfg_we,
	input  logic [pfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfr_pkg::CFG_W-1:0]       cfg_data
);
	import pfr_pkg::*;

	pfr_cmd_t  cmd;
	pfr_stat_t stat;
	logic      in_ready;

	assign ch_in.ready = in_ready;

	pfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ch_in.valid),
		.in_cmd   (ch_in.cmd),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pfr_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.objective_0 (ch_in.objective_0),
		.objective_1 (ch_in.objective_1),
		.objective_2 (ch_in.objective_2),
		.source_tag  (ch_in.source_tag),
		.point_index (ch_in.point_index),
		.ch_out      (ch_out)
	);
endmodule

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfr_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 4;
	localparam int TARGET_ITEMS = 1650;
	localparam int PHASES       = 6;
	localparam int SMALL_SET    = 16;
	localparam int SET_LIMIT    = 24;
	localparam int HOLD_AT      = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_FROM   = 1000;
	localparam int QUIET_TO     = 1250;
	localparam int IDLE_PCT     = 30;
	localparam int TAIL_CYCLES  = 16;
	localparam int DRAIN_LIMIT  = 4000000;
	localparam longint RUN_LIMIT_NS = 200_000_000;

	localparam logic [OBJ_W-1:0] OBJ_MIN = 32'h8000_0000;
	localparam logic [OBJ_W-1:0] OBJ_MAX = 32'h7FFF_FFFF;

	// how the objectives of one batch of points are spread
	typedef enum int {
		SHAPE_WIDE,
		SHAPE_GRID,
		SHAPE_EXTREME,
		SHAPE_CHAIN
	} shape_e;

	typedef logic [2:0][OBJ_W-1:0] triple_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [OBJ_W-1:0]  objective_0;
		logic [OBJ_W-1:0]  objective_1;
		logic [OBJ_W-1:0]  objective_2;
		logic [TAG_W-1:0]  source_tag;
		logic [PIDX_W-1:0] point_index;
	} command_t;

	typedef struct packed {
		logic                 result_kind;
		logic [OUT_CNT_W-1:0] front_one_group_a;
		logic [OUT_CNT_W-1:0] front_one_group_b;
		logic [OUT_CNT_W-1:0] point_rank;
		logic [OUT_CNT_W-1:0] points_loaded;
		logic                 load_overflow;
	} reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	pfr_in_if  cmd_ch ();
	pfr_out_if reply_ch ();

	pareto_front_ranker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ch_in     (cmd_ch),
		.ch_out    (reply_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// mirror of the point set and registers
	logic [OBJ_W-1:0] held_obj [MAX_POINTS][NUM_OBJECTIVES];
	logic [TAG_W-1:0] held_tag [MAX_POINTS];
	int unsigned      held_rank [MAX_POINTS];
	int unsigned      held_count;
	bit               held_overflow;
	logic [TOL_W-1:0] tolerance;
	logic [TAG_W-1:0] group_a;
	logic [TAG_W-1:0] group_b;

	command_t pending_cmds [$];
	reply_t   awaited_replies [$];
	command_t on_bus;

	int items_taken;
	int hold_left;
	bit hold_spent;
	int failures;
	int replies_seen;
	int n_loads, n_ranks, n_reads, n_clears;
	int deepest_front;
	int overflow_replies;
	int settings_used;
	int unsigned planned;
	int unsigned queued_items;

	// true when point p beats point q under minimization
	function automatic bit dominates_pt(int p, int q);
		longint a, b, tol;
		bit apart;
		int k;
		tol = (tolerance == '0) ? 1 : longint'(tolerance);
		apart = 1'b0;
		for (k = 0; k < NUM_OBJECTIVES; k++) begin
			a = longint'($signed(held_obj[p][k]));
			b = longint'($signed(held_obj[q][k]));
			if (a > b)
				return 1'b0;
			if (b - a >= tol)
				apart = 1'b1;
		end
		return apart;
	endfunction

	// peel the held set into fronts numbered from 1
	function automatic void peel_fronts();
		bit placed [MAX_POINTS];
		bit beaten [MAX_POINTS];
		int unsigned left, front;
		int i, j;
		for (i = 0; i < held_count; i++) begin
			held_rank[i] = 0;
			placed[i] = 1'b0;
		end
		left = held_count;
		front = 0;
		while (left > 0) begin
			front++;
			for (i = 0; i < held_count; i++) begin
				beaten[i] = 1'b0;
				if (!placed[i]) begin
					for (j = 0; j < held_count; j++) begin
						if (j != i && !placed[j] && dominates_pt(j, i)) begin
							beaten[i] = 1'b1;
							break;
						end
					end
				end
			end
			for (i = 0; i < held_count; i++) begin
				if (!placed[i] && !beaten[i]) begin
					placed[i] = 1'b1;
					held_rank[i] = front;
					left--;
				end
			end
		end
		if (front > deepest_front)
			deepest_front = front;
	endfunction

	// update the mirror with one transfer and queue the reply it causes
	function automatic void mirror_command(command_t c);
		reply_t r;
		int unsigned na, nb;
		int i, k;
		r = '0;
		case (c.cmd)
			CMD_LOAD: begin
				n_loads++;
				if (held_count >= MAX_POINTS) begin
					held_overflow = 1'b1;
				end else begin
					held_obj[held_count][0] = c.objective_0;
					held_obj[held_count][1] = c.objective_1;
					held_obj[held_count][2] = c.objective_2;
					for (k = IN_OBJECTIVES; k < NUM_OBJECTIVES; k++)
						held_obj[held_count][k] = '0;
					held_tag[held_count] = c.source_tag;
					held_rank[held_count] = 0;
					held_count++;
				end
			end
			CMD_CLEAR: begin
				n_clears++;
				held_count = 0;
				held_overflow = 1'b0;
				for (i = 0; i < MAX_POINTS; i++)
					held_rank[i] = 0;
			end
			default: begin
				r.points_loaded = OUT_CNT_W'(held_count);
				r.load_overflow = held_overflow;
				if (c.cmd == CMD_RANK) begin
					n_ranks++;
					peel_fronts();
					r.result_kind = KIND_REPORT;
					na = 0;
					nb = 0;
					for (i = 0; i < held_count; i++) begin
						if (held_rank[i] == 1) begin
							if (held_tag[i] == group_a)
								na++;
							else if (held_tag[i] == group_b)
								nb++;
						end
					end
					r.front_one_group_a = OUT_CNT_W'(na);
					r.front_one_group_b = OUT_CNT_W'(nb);
				end else begin
					n_reads++;
					r.result_kind = KIND_READ;
					if (c.point_index < held_count)
						r.point_rank = OUT_CNT_W'(held_rank[c.point_index]);
				end
				if (r.load_overflow)
					overflow_replies++;
				awaited_replies.push_back(r);
			end
		endcase
	endfunction

	function automatic void compare_field(string name, logic [OUT_CNT_W-1:0] want,
		logic [OUT_CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	function automatic void check_reply(reply_t got);
		reply_t want;
		if (awaited_replies.size() == 0) begin
			$error("reply of kind %0d arrived with none awaited", got.result_kind);
			failures++;
			return;
		end
		want = awaited_replies.pop_front();
		replies_seen++;
		compare_field("result_kind", OUT_CNT_W'(want.result_kind), OUT_CNT_W'(got.result_kind));
		compare_field("front_one_group_a", want.front_one_group_a, got.front_one_group_a);
		compare_field("front_one_group_b", want.front_one_group_b, got.front_one_group_b);
		compare_field("point_rank", want.point_rank, got.point_rank);
		compare_field("points_loaded", want.points_loaded, got.points_loaded);
		compare_field("load_overflow", OUT_CNT_W'(want.load_overflow),
			OUT_CNT_W'(got.load_overflow));
	endfunction

	function automatic bit noisy_now();
		return !(items_taken >= QUIET_FROM && items_taken < QUIET_TO);
	endfunction

	// drive commands; record each transfer in the mirror
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid       <= 1'b0;
			cmd_ch.cmd         <= CMD_LOAD;
			cmd_ch.objective_0 <= '0;
			cmd_ch.objective_1 <= '0;
			cmd_ch.objective_2 <= '0;
			cmd_ch.source_tag  <= '0;
			cmd_ch.point_index <= '0;
			items_taken        <= 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				mirror_command(on_bus);
				items_taken <= items_taken + 1;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending_cmds.size() != 0 &&
					!(noisy_now() && $urandom_range(99) < IDLE_PCT)) begin
					on_bus = pending_cmds.pop_front();
					cmd_ch.valid       <= 1'b1;
					cmd_ch.cmd         <= on_bus.cmd;
					cmd_ch.objective_0 <= on_bus.objective_0;
					cmd_ch.objective_1 <= on_bus.objective_1;
					cmd_ch.objective_2 <= on_bus.objective_2;
					cmd_ch.source_tag  <= on_bus.source_tag;
					cmd_ch.point_index <= on_bus.point_index;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// hold off the reply side once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_spent <= 1'b0;
		end else if (!hold_spent && items_taken >= HOLD_AT) begin
			hold_left  <= HOLD_CYCLES;
			hold_spent <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// take replies and check them against the oldest awaited one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_ch.ready <= 1'b0;
		end else begin
			if (reply_ch.valid && reply_ch.ready)
				check_reply({reply_ch.result_kind, reply_ch.front_one_group_a,
					reply_ch.front_one_group_b, reply_ch.point_rank,
					reply_ch.points_loaded, reply_ch.load_overflow});
			reply_ch.ready <= (hold_left == 0) &&
				!(noisy_now() && $urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic program_regs(logic [TOL_W-1:0] tol, logic [TAG_W-1:0] ga,
		logic [TAG_W-1:0] gb);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TOL;
		cfg_data  <= tol;
		@(posedge clk);
		cfg_index <= CFG_GROUP_A;
		cfg_data  <= {(CFG_W-TAG_W)'($urandom), ga};
		@(posedge clk);
		cfg_index <= CFG_GROUP_B;
		cfg_data  <= {(CFG_W-TAG_W)'($urandom), gb};
		@(posedge clk);
		cfg_we <= 1'b0;
		tolerance = tol;
		group_a = ga;
		group_b = gb;
		settings_used++;
	endtask

	// wait until every command is taken and every reply is in, then settle
	task automatic wait_idle();
		int waited;
		waited = 0;
		while ((pending_cmds.size() != 0 || cmd_ch.valid || awaited_replies.size() != 0) &&
			waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic triple_t pt(logic [OBJ_W-1:0] o0, logic [OBJ_W-1:0] o1,
		logic [OBJ_W-1:0] o2);
		return {o2, o1, o0};
	endfunction

	function automatic void queue_load(triple_t p, logic [TAG_W-1:0] tag);
		command_t c;
		c.cmd         = CMD_LOAD;
		c.objective_0 = p[0];
		c.objective_1 = p[1];
		c.objective_2 = p[2];
		c.source_tag  = tag;
		c.point_index = PIDX_W'($urandom);
		pending_cmds.push_back(c);
		queued_items++;
		if (planned < MAX_POINTS)
			planned++;
	endfunction

	function automatic void queue_op(logic [CMD_W-1:0] op, logic [PIDX_W-1:0] idx);
		command_t c;
		c.cmd         = op;
		c.objective_0 = $urandom;
		c.objective_1 = $urandom;
		c.objective_2 = $urandom;
		c.source_tag  = TAG_W'($urandom);
		c.point_index = idx;
		pending_cmds.push_back(c);
		queued_items++;
		if (op == CMD_CLEAR)
			planned = 0;
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		int roll;
		roll = $urandom_range(99);
		if (roll < 35)
			return group_a;
		if (roll < 70)
			return group_b;
		return TAG_W'($urandom);
	endfunction

	function automatic logic [PIDX_W-1:0] pick_index();
		if (planned > 0 && $urandom_range(99) < 85)
			return PIDX_W'($urandom_range(0, planned - 1));
		return PIDX_W'($urandom);
	endfunction

	function automatic logic [OBJ_W-1:0] extreme_value(int sel);
		case (sel)
			0: return OBJ_MIN;
			1: return OBJ_MIN + 1;
			2: return '1;
			3: return '0;
			4: return 32'd1;
			5: return OBJ_MAX - 1;
			default: return OBJ_MAX;
		endcase
	endfunction

	function automatic triple_t make_point(shape_e shape, int pos, triple_t base);
		triple_t p;
		int step, k;
		step = (tolerance == '0) ? 1 : int'(tolerance);
		for (k = 0; k < 3; k++) begin
			case (shape)
				SHAPE_WIDE:    p[k] = $urandom;
				// offsets straddle the tolerance so near-ties show up
				SHAPE_GRID:    p[k] = base[k] + $urandom_range(0, 3) * step +
					$urandom_range(0, 2) - 1;
				SHAPE_EXTREME: p[k] = extreme_value($urandom_range(0, 6));
				// rising diagonal: each step beats the next, so fronts run deep
				default:       p[k] = base[k] + pos * 2 * step + $urandom_range(0, step);
			endcase
		end
		return p;
	endfunction

	// fill the store with one front, overflow it, rank and read around it
	function automatic void queue_fill();
		triple_t p;
		int i, gap;
		logic [OBJ_W-1:0] s0, s1;
		queue_op(CMD_CLEAR, PIDX_W'($urandom));
		gap = $urandom_range(1, 1000);
		s0 = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
		s1 = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
		for (i = 0; i < MAX_POINTS + $urandom_range(1, 3); i++) begin
			p[0] = s0 + i * gap;
			p[1] = s1 - i * gap;
			p[2] = $urandom;
			queue_load(p, pick_tag());
		end
		queue_op(CMD_READ, pick_index());
		queue_op(CMD_RANK, PIDX_W'($urandom));
		queue_op(CMD_READ, '0);
		queue_op(CMD_READ, PIDX_W'(MAX_POINTS - 1));
		repeat (3) queue_op(CMD_READ, pick_index());
		queue_op(CMD_CLEAR, PIDX_W'($urandom));
		queue_op(CMD_READ, pick_index());
		queue_op(CMD_RANK, PIDX_W'($urandom));
	endfunction

	// one load / rank / read round with random content, or a burst of noise
	function automatic void queue_episode();
		triple_t made [$];
		triple_t base, p;
		shape_e shape;
		int n, i, k;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(1, 6)) begin
				k = $urandom_range(0, 3);
				case (CMD_W'(k))
					CMD_LOAD:  queue_load(make_point(SHAPE_WIDE, 0, '0), TAG_W'($urandom));
					CMD_RANK:  queue_op((planned <= SET_LIMIT) ? CMD_RANK : CMD_CLEAR,
						PIDX_W'($urandom));
					CMD_READ:  queue_op(CMD_READ, PIDX_W'($urandom));
					default:   queue_op(CMD_CLEAR, PIDX_W'($urandom));
				endcase
			end
			return;
		end
		shape = shape_e'($urandom_range(0, 3));
		for (k = 0; k < 3; k++)
			base[k] = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
		n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, SMALL_SET);
		if (planned + n + 3 > SET_LIMIT || $urandom_range(0, 3) != 0)
			queue_op(CMD_CLEAR, PIDX_W'($urandom));
		for (i = 0; i < n; i++) begin
			if (made.size() != 0 && $urandom_range(0, 4) == 0)
				p = made[$urandom_range(0, made.size() - 1)];
			else
				p = make_point(shape, $urandom_range(0, n - 1), base);
			made.push_back(p);
			queue_load(p, pick_tag());
		end
		queue_op(CMD_RANK, PIDX_W'($urandom));
		repeat ($urandom_range(1, 6)) queue_op(CMD_READ, pick_index());
		// late loads stay unranked until the next rank pass
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 3))
				queue_load(make_point(shape, $urandom_range(0, SMALL_SET), base), pick_tag());
			repeat ($urandom_range(1, 4)) queue_op(CMD_READ, pick_index());
			if ($urandom_range(0, 1) == 0) begin
				queue_op(CMD_RANK, PIDX_W'($urandom));
				repeat ($urandom_range(1, 4)) queue_op(CMD_READ, pick_index());
			end
		end
	endfunction

	// reset values, extreme points, ties, reads out of range, load after rank
	function automatic void queue_directed();
		queue_op(CMD_READ, '0);
		queue_op(CMD_RANK, PIDX_W'($urandom));
		queue_load(pt(OBJ_MIN, OBJ_MIN, OBJ_MIN), 4'd0);
		queue_load(pt(OBJ_MAX, OBJ_MAX, OBJ_MAX), 4'd15);
		queue_load(pt('0, '0, '0), 4'd1);
		queue_load(pt('0, '0, '0), 4'd1);
		queue_load(pt('0, '0, 32'd1), 4'd0);
		queue_op(CMD_READ, 7'd1);
		queue_op(CMD_RANK, PIDX_W'($urandom));
		for (int i = 0; i < 5; i++)
			queue_op(CMD_READ, PIDX_W'(i));
		queue_op(CMD_READ, 7'd127);
		queue_load(pt(OBJ_MIN, OBJ_MIN, OBJ_MIN), 4'd1);
		queue_op(CMD_READ, 7'd5);
		queue_op(CMD_READ, 7'd2);
		queue_op(CMD_RANK, PIDX_W'($urandom));
		queue_op(CMD_READ, 7'd5);
		queue_op(CMD_CLEAR, PIDX_W'($urandom));
		queue_op(CMD_READ, '0);
		queue_op(CMD_RANK, PIDX_W'($urandom));
	endfunction

	initial begin
		int phase;
		int unsigned budget, start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TOL;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = CMD_LOAD;
		cmd_ch.objective_0 = '0;
		cmd_ch.objective_1 = '0;
		cmd_ch.objective_2 = '0;
		cmd_ch.source_tag = '0;
		cmd_ch.point_index = '0;
		reply_ch.ready = 1'b0;
		held_count = 0;
		held_overflow = 1'b0;
		for (int i = 0; i < MAX_POINTS; i++)
			held_rank[i] = 0;
		tolerance = 16'd1;
		group_a = 4'd0;
		group_b = 4'd1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_directed();
		wait_idle();

		budget = (TARGET_ITEMS - queued_items) / PHASES;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: program_regs(16'd1, 4'd0, 4'd1);
				1: program_regs(16'd0, 4'd7, 4'd7);
				2: program_regs(16'hFFFF, 4'hF, 4'h0);
				3: program_regs(TOL_W'($urandom_range(1, 300)), TAG_W'($urandom),
					TAG_W'($urandom));
				4: program_regs(TOL_W'($urandom), TAG_W'($urandom), TAG_W'($urandom));
				default: program_regs(16'd1, 4'd3, 4'd12);
			endcase
			start = queued_items;
			if (phase == 0 || phase == PHASES - 1)
				queue_fill();
			while (queued_items - start < budget)
				queue_episode();
			wait_idle();
		end

		if (awaited_replies.size() != 0) begin
			$error("%0d replies never arrived", awaited_replies.size());
			failures++;
		end
		$display("Covered %0d commands: %0d loads, %0d rank passes, %0d rank reads, %0d clears, %0d register settings",
			items_taken, n_loads, n_ranks, n_reads, n_clears, settings_used);
		$display("Checked %0d replies; deepest front %0d, %0d replies flagged overflow, %0d mismatches",
			replies_seen, deepest_front, overflow_replies, failures);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// stop a hung run
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ pareto_front_ranker_core.f @@
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_if.sv
hw/rtl/pfr_ram.sv
hw/rtl/pfr_ctrl.sv
hw/rtl/pfr_datapath.sv
hw/rtl/pareto_front_ranker_core.sv
tb/tb_top.sv
